[hw/rtl/lsr_pkg.sv]
// Shared constants, register codes and configuration type for the line rasterizer.
`default_nettype none
package lsr_pkg;

  localparam int COORD_BITS_DEF      = 12;
  localparam int SLOPE_FRAC_BITS_DEF = 16;
  localparam int CMD_DEPTH           = 4;
  localparam int OUT_DEPTH           = 8;
  localparam int ADDR_BITS           = 5;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH    = 3'd0,
    REG_SCREEN_HEIGHT   = 3'd1,
    REG_ROW_PITCH       = 3'd2,
    REG_BYTES_PER_PIXEL = 3'd3,
    REG_FRAME_BASE      = 3'd4,
    REG_DRAW_COLOR      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [14:0] row_pitch;
    logic [2:0]  bytes_per_pixel;
    logic [31:0] frame_base;
    logic [23:0] draw_color;
  } cfg_t;

  localparam logic [11:0] SCREEN_WIDTH_RST    = 12'd640;
  localparam logic [11:0] SCREEN_HEIGHT_RST   = 12'd480;
  localparam logic [14:0] ROW_PITCH_RST       = 15'd2560;
  localparam logic [2:0]  BYTES_PER_PIXEL_RST = 3'd4;
  localparam logic [31:0] FRAME_BASE_RST      = 32'd0;
  localparam logic [23:0] DRAW_COLOR_RST      = 24'd0;

endpackage
`default_nettype wire

[hw/rtl/line_segment_rasterizer.sv]
// Top level of the DDA line rasterizer: register file, intake, command queue, pixel engine.
//
//  channel   dir  transfer when                 payload
//  request   in   push && !full                 req_type, x_start, y_start, x_end, y_end
//  result    out  pop && !empty                 pixel_x, pixel_y, visible, byte_address,
//                                               pixel_color, last, no_segment
//  config    in   psel && penable && pwrite     paddr (4*index), pwdata, prdata
//
// Next-pixel requests sustain one transfer per cycle while the command queue has room.
// A segment load holds full during setup, while the serial divider runs.
// The 4-entry command queue separates intake from the pixel engine.
// The engine issues only with room in the 8-entry result queue, so a stalled pop
// backs up into full without loss. Reset is synchronous; no clearing pass.
`default_nettype none
module line_segment_rasterizer #(
  parameter int COORD_BITS      = lsr_pkg::COORD_BITS_DEF,
  parameter int SLOPE_FRAC_BITS = lsr_pkg::SLOPE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type,
  input  logic [COORD_BITS-1:0]         x_start,
  input  logic [COORD_BITS-1:0]         y_start,
  input  logic [COORD_BITS-1:0]         x_end,
  input  logic [COORD_BITS-1:0]         y_end,
  input  logic                          pop,
  output logic                          empty,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic                          visible,
  output logic [31:0]                   byte_address,
  output logic [23:0]                   pixel_color,
  output logic                          last,
  output logic                          no_segment,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lsr_pkg::*;

  localparam int CW  = 3*COORD_BITS + SLOPE_FRAC_BITS + 6;
  localparam int CQW = $clog2(CMD_DEPTH + 1);

  cfg_t           cfg;
  reg_idx_t       idx;
  logic           wr;
  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CW-1:0]  cmd_wdata, cmd_rdata;
  logic [CQW-1:0] cmd_count;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width    <= SCREEN_WIDTH_RST;
      cfg.screen_height   <= SCREEN_HEIGHT_RST;
      cfg.row_pitch       <= ROW_PITCH_RST;
      cfg.bytes_per_pixel <= BYTES_PER_PIXEL_RST;
      cfg.frame_base      <= FRAME_BASE_RST;
      cfg.draw_color      <= DRAW_COLOR_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SCREEN_WIDTH:    cfg.screen_width    <= pwdata[11:0];
        REG_SCREEN_HEIGHT:   cfg.screen_height   <= pwdata[11:0];
        REG_ROW_PITCH:       cfg.row_pitch       <= pwdata[14:0];
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= pwdata[2:0];
        REG_FRAME_BASE:      cfg.frame_base      <= pwdata;
        REG_DRAW_COLOR:      cfg.draw_color      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCREEN_WIDTH:    prdata = 32'(cfg.screen_width);
      REG_SCREEN_HEIGHT:   prdata = 32'(cfg.screen_height);
      REG_ROW_PITCH:       prdata = 32'(cfg.row_pitch);
      REG_BYTES_PER_PIXEL: prdata = 32'(cfg.bytes_per_pixel);
      REG_FRAME_BASE:      prdata = cfg.frame_base;
      REG_DRAW_COLOR:      prdata = 32'(cfg.draw_color);
      default:             prdata = '0;
    endcase
  end

  lsr_front #(
    .COORD_BITS      (COORD_BITS),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req_type (req_type),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata),
    .cmd_full (cmd_full)
  );

  lsr_fifo #(
    .WIDTH (CW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  lsr_back #(
    .COORD_BITS      (COORD_BITS),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .cmd_data     (cmd_rdata),
    .pop          (pop),
    .empty        (empty),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .visible      (visible),
    .byte_address (byte_address),
    .pixel_color  (pixel_color),
    .last         (last),
    .no_segment   (no_segment)
  );

  a_cmd_count: assert property (@(posedge clk) disable iff (rst)
    cmd_full |-> (cmd_count == CQW'(CMD_DEPTH))) else $error("command queue count");
  a_cmd_flow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty) else $error("pop from empty command queue");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    cmd_full |-> full) else $error("intake open with full command queue");
endmodule
`default_nettype wire

[hw/rtl/lsr_fifo.sv]
// Small register-based FIFO used for the command queue and the result queue.
`default_nettype none
module lsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  output logic                           full,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNW'(1);
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/lsr_front.sv]
// Request intake: classifies requests and runs segment setup with a serial slope divider.
`default_nettype none
module lsr_front #(
  parameter int COORD_BITS      = 12,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        push,
  output logic                                        full,
  input  logic                                        req_type,
  input  logic [COORD_BITS-1:0]                       x_start,
  input  logic [COORD_BITS-1:0]                       y_start,
  input  logic [COORD_BITS-1:0]                       x_end,
  input  logic [COORD_BITS-1:0]                       y_end,
  output logic                                        cmd_push,
  output logic [3*COORD_BITS+SLOPE_FRAC_BITS+5:0]     cmd_data,
  input  logic                                        cmd_full
);
  localparam int C  = COORD_BITS;
  localparam int F  = SLOPE_FRAC_BITS;
  localparam int NW = C + F + 1;
  localparam int IW = $clog2(F + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_PREP, S_LOAD, S_DIV, S_PUSH
  } state_t;

  state_t        state;
  logic [C-1:0]  x0, y0, x1, y1;
  logic [C:0]    dx, dy;
  logic [C-1:0]  amaj, amin;
  logic          walk, sneg, mneg;
  logic [C-1:0]  rem;
  logic [F:0]    nlow;
  logic [F:0]    quo;
  logic [IW-1:0] cnt;

  logic          accept;
  logic [C:0]    adx, ady;
  logic [NW-1:0] num;
  logic [C:0]    trial;
  logic [C:0]    trial_sub;
  logic          ge;
  logic [F:0]    slope_mag;

  assign full      = (state != S_IDLE) || cmd_full;
  assign accept    = push && !full;
  assign adx       = dx[C] ? -dx : dx;
  assign ady       = dy[C] ? -dy : dy;
  assign num       = {1'b0, amin, {F{1'b0}}} + NW'(amaj >> 1);
  assign trial     = {rem, nlow[F]};
  assign ge        = trial >= {1'b0, amaj};
  assign trial_sub = trial - {1'b0, amaj};
  assign slope_mag = (amaj == '0) ? '0 : quo;

  assign cmd_push = (accept && req_type) || (state == S_PUSH && !cmd_full);
  assign cmd_data = (state == S_PUSH) ?
                    {1'b1, x0, y0, walk, sneg, mneg, slope_mag, 1'b0, amaj} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && !req_type) begin
            x0    <= x_start;
            y0    <= y_start;
            x1    <= x_end;
            y1    <= y_end;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          dx    <= {x1[C-1], x1} - {x0[C-1], x0};
          dy    <= {y1[C-1], y1} - {y0[C-1], y0};
          state <= S_PREP;
        end
        S_PREP: begin
          walk <= adx >= ady;
          if (adx >= ady) begin
            amaj <= adx[C-1:0];
            amin <= ady[C-1:0];
            sneg <= dx[C];
            mneg <= dy[C];
          end else begin
            amaj <= ady[C-1:0];
            amin <= adx[C-1:0];
            sneg <= dy[C];
            mneg <= dx[C];
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          rem   <= num[NW-1:F+1];
          nlow  <= num[F:0];
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? trial_sub[C-1:0] : trial[C-1:0];
          nlow <= {nlow[F-1:0], 1'b0};
          quo  <= {quo[F-1:0], ge};
          cnt  <= cnt + IW'(1);
          if (cnt == IW'(F)) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!cmd_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> full) else $error("front busy but not full");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full) else $error("command pushed into full queue");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == IW'(F)) |=> (state == S_PUSH))
    else $error("divider did not finish");
endmodule
`default_nettype wire

[hw/rtl/lsr_back.sv]
// Pixel engine: segment walk, rounding, address pipeline and result queue.
`default_nettype none
module lsr_back #(
  parameter int COORD_BITS      = 12,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  lsr_pkg::cfg_t                            cfg,
  input  logic                                     cmd_empty,
  output logic                                     cmd_pop,
  input  logic [3*COORD_BITS+SLOPE_FRAC_BITS+5:0]  cmd_data,
  input  logic                                     pop,
  output logic                                     empty,
  output logic [COORD_BITS-1:0]                    pixel_x,
  output logic [COORD_BITS-1:0]                    pixel_y,
  output logic                                     visible,
  output logic [31:0]                              byte_address,
  output logic [23:0]                              pixel_color,
  output logic                                     last,
  output logic                                     no_segment
);
  import lsr_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = SLOPE_FRAC_BITS;
  localparam int AW  = F + C + 1;
  localparam int OW  = 2*C + 59;
  localparam int CNW = $clog2(OUT_DEPTH + 1);
  localparam logic [F-1:0] HALF = {1'b1, {(F-1){1'b0}}};

  logic         c_new, c_walk, c_sneg, c_mneg;
  logic [C-1:0] c_ox, c_oy;
  logic [F:0]   c_slope;
  logic [C:0]   c_total;

  assign {c_new, c_ox, c_oy, c_walk, c_sneg, c_mneg, c_slope, c_total} = cmd_data;

  // segment state
  logic         active, walk, sneg, mneg;
  logic [C-1:0] ox, oy;
  logic [F:0]   slope;
  logic [C:0]   total, k;
  logic [AW-1:0] acc;

  // stage 1
  logic         v1, nos1, last1, walk1, sneg1, mneg1;
  logic [C-1:0] ox1, oy1;
  logic [C:0]   k1;
  logic [AW-1:0] acc1;
  // stage 2
  logic         v2, nos2, last2, walk2, sneg2, mneg2;
  logic [C-1:0] ox2, oy2, k2, q2;
  // stage 3
  logic         v3, nos3, last3;
  logic [C-1:0] x3, y3;
  // stage 4
  logic         v4, nos4, last4, vis4;
  logic [C-1:0] x4, y4;
  logic [31:0]  yp4, xp4;

  logic           out_full;
  logic [CNW-1:0] out_count;
  logic [CNW+1:0] inflight;
  logic           out_push;
  logic [OW-1:0]  out_wdata, out_rdata;

  logic [C:0]   q1;
  logic [F-1:0] r1;
  logic         up1;
  logic [C-1:0] off2, mj2;
  logic [31:0]  xs3, ys3, addr4;
  logic         last_now;

  assign inflight = (CNW+2)'(out_count) + (CNW+2)'(v1) + (CNW+2)'(v2)
                  + (CNW+2)'(v3) + (CNW+2)'(v4);
  assign cmd_pop  = !cmd_empty && (inflight < (CNW+2)'(OUT_DEPTH));
  assign last_now = (k == total);

  assign q1  = acc1[AW-1:F];
  assign r1  = acc1[F-1:0];
  assign up1 = (r1 > HALF) || (r1 == HALF && q1[0]);

  assign off2 = mneg2 ? -q2 : q2;
  assign mj2  = sneg2 ? -k2 : k2;

  assign xs3 = {{(32-C){x3[C-1]}}, x3};
  assign ys3 = {{(32-C){y3[C-1]}}, y3};

  assign addr4    = cfg.frame_base + yp4 + xp4;
  assign out_push = v4;
  assign out_wdata = nos4 ? {{(OW-1){1'b0}}, 1'b1}
                          : {x4, y4, vis4, addr4, cfg.draw_color, last4, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
    end else begin
      v1 <= cmd_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (cmd_pop) begin
        priority if (c_new) begin
          nos1   <= 1'b0;
          last1  <= (c_total == '0);
          ox1    <= c_ox;
          oy1    <= c_oy;
          walk1  <= c_walk;
          sneg1  <= c_sneg;
          mneg1  <= c_mneg;
          k1     <= '0;
          acc1   <= '0;
          active <= (c_total != '0);
          ox     <= c_ox;
          oy     <= c_oy;
          walk   <= c_walk;
          sneg   <= c_sneg;
          mneg   <= c_mneg;
          slope  <= c_slope;
          total  <= c_total;
          k      <= (C+1)'(1);
          acc    <= AW'(c_slope);
        end else if (!active) begin
          nos1  <= 1'b1;
          last1 <= 1'b0;
        end else begin
          nos1  <= 1'b0;
          last1 <= last_now;
          ox1   <= ox;
          oy1   <= oy;
          walk1 <= walk;
          sneg1 <= sneg;
          mneg1 <= mneg;
          k1    <= k;
          acc1  <= acc;
          if (last_now) begin
            active <= 1'b0;
          end else begin
            k   <= k + (C+1)'(1);
            acc <= acc + AW'(slope);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    nos2  <= nos1;
    last2 <= last1;
    walk2 <= walk1;
    sneg2 <= sneg1;
    mneg2 <= mneg1;
    ox2   <= ox1;
    oy2   <= oy1;
    k2    <= k1[C-1:0];
    q2    <= q1[C-1:0] + C'(up1);

    nos3  <= nos2;
    last3 <= last2;
    if (walk2) begin
      x3 <= ox2 + mj2;
      y3 <= oy2 + off2;
    end else begin
      x3 <= ox2 + off2;
      y3 <= oy2 + mj2;
    end

    nos4  <= nos3;
    last4 <= last3;
    x4    <= x3;
    y4    <= y3;
    vis4  <= !x3[C-1] && !y3[C-1] && (32'(x3) < 32'(cfg.screen_width))
             && (32'(y3) < 32'(cfg.screen_height));
    yp4   <= ys3 * 32'(cfg.row_pitch);
    xp4   <= xs3 * 32'(cfg.bytes_per_pixel);
  end

  lsr_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign {pixel_x, pixel_y, visible, byte_address, pixel_color, last, no_segment} = out_rdata;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full) else $error("result queue overflow");
  a_point_done: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && c_new && c_total == '0) |=> !active)
    else $error("single point left segment active");
  a_nos_not_last: assert property (@(posedge clk) disable iff (rst)
    (v1 && nos1) |-> !last1) else $error("idle request flagged last");
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for line_segment_rasterizer: random segments, pixel walks, register settings.
`timescale 1ns / 1ps
module tb;
  import lsr_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 200;
  localparam int PHASES       = 8;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        vis;
    logic [31:0] addr;
    logic [23:0] color;
    logic        last;
    logic        noseg;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t due[$];
    int     mismatches;
    int     checked;
    longint width, height, pitch, bpp, base, color;
    bit     active, walk_cols, step_neg;
    longint org_x, org_y, slope, step, span;

    function new();
      width  = SCREEN_WIDTH_RST;
      height = SCREEN_HEIGHT_RST;
      pitch  = ROW_PITCH_RST;
      bpp    = BYTES_PER_PIXEL_RST;
      base   = FRAME_BASE_RST;
      color  = DRAW_COLOR_RST;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_SCREEN_WIDTH: width = v[11:0];
        REG_SCREEN_HEIGHT: height = v[11:0];
        REG_ROW_PITCH: pitch = v[14:0];
        REG_BYTES_PER_PIXEL: bpp = v[2:0];
        REG_FRAME_BASE: base = v;
        REG_DRAW_COLOR: color = v[23:0];
        default: ;
      endcase
    endfunction

    // Pixel at the current step; advances the walk, or ends it at the last step.
    function pixel_t trace_pixel();
      pixel_t p;
      longint prod, mag, q, r, off, mj, xw, yw, xs, ys, addr64;
      bit neg;
      prod = slope * step;
      neg = prod < 0;
      mag = neg ? -prod : prod;
      q = mag >> 16;
      r = mag & 64'hFFFF;
      if (r > 32768 || (r == 32768 && q[0])) q = q + 1;
      off = neg ? -q : q;
      mj = step_neg ? -step : step;
      if (walk_cols) begin
        xw = org_x + mj;
        yw = org_y + off;
      end else begin
        xw = org_x + off;
        yw = org_y + mj;
      end
      p.px = xw[11:0];
      p.py = yw[11:0];
      xs = longint'($signed(p.px));
      ys = longint'($signed(p.py));
      p.vis = xs >= 0 && ys >= 0 && xs < width && ys < height;
      addr64 = base + ys * pitch + xs * bpp;
      p.addr = addr64[31:0];
      p.color = color[23:0];
      p.last = step == span;
      p.noseg = 1'b0;
      if (p.last) active = 1'b0;
      else step = (step + 1) & 64'h1FFF;
      return p;
    endfunction

    function void note_request(bit nxt, logic [11:0] xa, logic [11:0] ya,
                               logic [11:0] xb, logic [11:0] yb);
      longint x0, y0, dx, dy, adx, ady, dmaj, dmin, amaj, amin, q;
      if (nxt) begin
        if (!active) due.push_back('{noseg: 1'b1, default: '0});
        else due.push_back(trace_pixel());
        return;
      end
      x0 = longint'($signed(xa));
      y0 = longint'($signed(ya));
      dx = longint'($signed(xb)) - x0;
      dy = longint'($signed(yb)) - y0;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      walk_cols = adx >= ady;
      dmaj = walk_cols ? dx : dy;
      dmin = walk_cols ? dy : dx;
      amaj = walk_cols ? adx : ady;
      step_neg = dmaj < 0;
      slope = 0;
      if (amaj != 0) begin
        amin = dmin < 0 ? -dmin : dmin;
        q = ((amin << 16) + amaj / 2) / amaj;
        slope = dmin < 0 ? -q : q;
      end
      org_x = x0;
      org_y = y0;
      span = amaj;
      step = 0;
      active = 1'b1;
      due.push_back(trace_pixel());
    endfunction

    function string describe(pixel_t p);
      return $sformatf("x=%0d y=%0d vis=%0b addr=%h color=%h last=%0b noseg=%0b",
                       $signed(p.px), $signed(p.py), p.vis, p.addr, p.color, p.last,
                       p.noseg);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp;
      checked++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel transfer: %s", describe(got));
        return;
      end
      exp = due.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel %0d mismatch\n  expected %s\n  actual   %s", checked,
                   describe(exp), describe(got));
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        push, full, req_type;
  logic [11:0] x_start, y_start, x_end, y_end;
  logic        pop, empty;
  logic [11:0] pixel_x, pixel_y;
  logic        visible;
  logic [31:0] byte_address;
  logic [23:0] pixel_color;
  logic        last, no_segment;
  logic        psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  pixel_scoreboard sb = new();
  bit quiet;
  int n_sent, n_loads, n_nexts, n_settings, stall_cycles;

  line_segment_rasterizer DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_pixel({pixel_x, pixel_y, visible, byte_address, pixel_color, last,
                      no_segment});
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [11:0] any_coord();
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [11:0] near(logic [11:0] c, int reach);
    int d, v;
    d = int'($urandom_range(0, 2 * reach)) - reach;
    v = int'($signed(c)) + d;
    if (v > 2047 || v < -2048) v = int'($signed(c)) - d;
    return v[11:0];
  endfunction

  // Called at a falling edge; returns at a falling edge with push still high.
  task automatic send_req(bit nxt, logic [11:0] xa, logic [11:0] ya,
                          logic [11:0] xb, logic [11:0] yb);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    req_type <= nxt;
    x_start  <= xa;
    y_start  <= ya;
    x_end    <= xb;
    y_end    <= yb;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_request(nxt, xa, ya, xb, yb);
    n_sent++;
    if (nxt) n_nexts++;
    else n_loads++;
    @(negedge clk);
  endtask

  task automatic send_next();
    send_req(1'b1, any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  task automatic send_segment(int xa, int ya, int xb, int yb, int walk);
    send_req(1'b0, 12'(xa), 12'(ya), 12'(xb), 12'(yb));
    repeat (walk) send_next();
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [31:0] w, logic [31:0] h, logic [31:0] p,
                                logic [31:0] b, logic [31:0] fb, logic [31:0] col);
    write_register(REG_SCREEN_WIDTH, w);
    write_register(REG_SCREEN_HEIGHT, h);
    write_register(REG_ROW_PITCH, p);
    write_register(REG_BYTES_PER_PIXEL, b);
    write_register(REG_FRAME_BASE, fb);
    write_register(REG_DRAW_COLOR, col);
    n_settings++;
  endtask

  task automatic random_burst();
    int pick, reach, walk, span, dx, dy;
    logic [11:0] xa, ya, xb, yb;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_next();
      return;
    end
    xa = $urandom_range(0, 1) ? any_coord() : 12'($urandom_range(0, 700));
    ya = $urandom_range(0, 1) ? any_coord() : 12'($urandom_range(0, 700));
    if (pick < 12) begin
      xb = any_coord();
      yb = any_coord();
    end else begin
      reach = pick < 15 ? 300 : (pick < 55 ? 3 : 24);
      xb = near(xa, reach);
      yb = near(ya, reach);
    end
    dx = int'($signed(xb)) - int'($signed(xa));
    dy = int'($signed(yb)) - int'($signed(ya));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    span = dx >= dy ? dx : dy;
    walk = span;
    if (pick < 12) begin
      walk = $urandom_range(0, 30);
      if (walk > span) walk = span;
    end else if ($urandom_range(0, 9) == 0) begin
      walk = $urandom_range(0, span);
    end else if ($urandom_range(0, 9) == 0) begin
      walk = span + $urandom_range(1, 2);
    end
    send_req(1'b0, xa, ya, xb, yb);
    repeat (walk) send_next();
  endtask

  initial begin
    int start;
    rst      = 1'b1;
    push     = 1'b0;
    req_type = 1'b0;
    x_start  = '0;
    y_start  = '0;
    x_end    = '0;
    y_end    = '0;
    pop      = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle next, single point, tie rounding, steep, full-range, off-screen
    send_next();
    send_segment(5, 5, 5, 5, 0);
    send_next();
    send_segment(0, 0, 4, 1, 4);
    send_segment(10, 20, 8, 10, 2);
    send_segment(-2048, -2048, 2047, 2047, 2);
    send_segment(2047, -2048, -2048, 2047, 1);
    send_segment(-5, -3, -1, -6, 4);
    send_segment(3, 0, 0, 3, 3);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(640, 480, 2560, 4, 32'h0, 32'hFF_FFFF);
        1: apply_settings(4095, 4095, 32767, 7, 32'hFFFF_FFFF, 32'h0);
        2: apply_settings(2048, 2048, 16384, 1, 32'h8000_0000, 32'hA5_A5A5);
        3: apply_settings(1, 1, 1, 1, 32'h1000, 32'h12_3456);
        4: apply_settings(0, 0, 0, 0, 32'h0, 32'h0);
        default: apply_settings($urandom_range(1, 2048), $urandom_range(1, 2048),
                                $urandom_range(1, 16384), $urandom_range(1, 4),
                                $urandom, $urandom_range(0, 24'hFF_FFFF));
      endcase
      quiet = (p == 2);
      start = n_sent;
      while (n_sent - start < PHASE_ITEMS) random_burst();
      drain();
      quiet = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d expected pixels never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end
    $display("Sent %0d requests (%0d segment loads, %0d next-pixel) over %0d settings;",
             n_sent, n_loads, n_nexts, n_settings);
    $display("checked %0d pixel transfers, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
